@@ rtl/knob_tuned_synth_divider_macros.svh @@
// Assertion macros shared by the knob-tuned synthesizer divider RTL.
`ifndef KNOB_TUNED_SYNTH_DIVIDER_MACROS_SVH
`define KNOB_TUNED_SYNTH_DIVIDER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define KTSD_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define KTSD_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ rtl/ktsd_pkg.sv @@
// Types, constants and helper functions for the knob-tuned synthesizer divider.
`timescale 1ns / 1ps
package ktsd_pkg;

  localparam int unsigned VcoWidth   = 30;
  localparam int unsigned FreqWidth  = 24;
  localparam int unsigned DivNumW    = 44;
  localparam logic [VcoWidth-1:0]  VcoReset  = 30'd900000000;
  localparam logic [FreqWidth-1:0] FracLimit = 24'h0FFFFF;

  // divider operation codes
  localparam logic [2:0] OP_VCO = 3'd0;
  localparam logic [2:0] OP_EUC = 3'd1;
  localparam logic [2:0] OP_NUM = 3'd2;
  localparam logic [2:0] OP_DEN = 3'd3;
  localparam logic [2:0] OP_SCL = 3'd4;

  typedef struct packed {
    logic        encoder_present;
    logic        button_pressed;
    logic        knob_moved;
    logic        turn_left;
    logic [15:0] rotation_count;
  } in_t;

  typedef struct packed {
    logic        event_handled;
    logic        pll_updated;
    logic [23:0] frequency_hz;
    logic [2:0]  cursor_position;
    logic [6:0]  divider_integer;
    logic [19:0] divider_numerator;
    logic [19:0] divider_denominator;
    logic [6:0]  quadrature_phase;
    logic [7:0]  led_red;
    logic [7:0]  led_green;
    logic [7:0]  led_blue;
    logic        scroll_active;
  } out_t;

  typedef struct packed {
    logic       capture;
    logic       f_load;
    logic       div_start;
    logic [2:0] div_op;
    logic       res_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic x_zero;
    logic den_big;
    logic calc_ok;
  } status_t;

  // 16-bit value mod 7: octal digit sum, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [15:0] v);
    logic [5:0] s;
    logic [3:0] t;
    s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
      + 6'(v[14:12]) + 6'(v[15]);
    t = 4'(s[5:3]) + 4'(s[2:0]);
    if (t >= 4'd7) t = t - 4'd7;
    return t[2:0];
  endfunction

  function automatic logic [23:0] colour(input logic [2:0] idx);
    logic [23:0] c;
    unique case (idx)
      3'd0:    c = {8'd255, 8'd0,   8'd0};
      3'd1:    c = {8'd255, 8'd165, 8'd0};
      3'd2:    c = {8'd255, 8'd255, 8'd0};
      3'd3:    c = {8'd0,   8'd128, 8'd0};
      3'd4:    c = {8'd0,   8'd0,   8'd255};
      3'd5:    c = {8'd75,  8'd0,   8'd130};
      3'd6:    c = {8'd238, 8'd130, 8'd238};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/knob_tuned_synth_divider.sv @@
// Top level of the knob-tuned synthesizer divider.
//
//   channel | direction | handshake              | beat payload
//   in      | input     | in_valid / in_ready    | ktsd_pkg::in_t
//   out     | output    | out_valid / out_ready  | ktsd_pkg::out_t
//   cfg     | input     | cfg_we                 | cfg_data (VCO frequency, Hz)
//
// One event at a time. Without a digit change the result reaches the output register
// through the FCAL, CHKF and DONE states, and the next event is taken back in IDLE.
// A digit change adds passes of the shared divider: one for the quotient, one per
// Euclid step (at most about 35), two for the reduction and one for any rescaling.
// Reset is synchronous; no clearing pass.
// A stalled output beat holds; the next input beat is taken while it waits.
`timescale 1ns / 1ps
module knob_tuned_synth_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ktsd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ktsd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [29:0]    cfg_data
);
  import ktsd_pkg::*;

  cmd_t    cmd;
  status_t st;

  ktsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ktsd_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

@@ rtl/ktsd_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ktsd_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [43:0] dividend,
  input  logic [23:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [43:0] quot,
  output logic [23:0] rem
);
  import ktsd_pkg::*;

  logic [43:0] quo;
  logic [23:0] rem_r;
  logic [23:0] dsr;
  logic [5:0]  cnt;
  logic [24:0] trial;
  logic        ge;

  assign trial = {rem_r, quo[DivNumW-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DivNumW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem_r <= '0;
      dsr   <= divisor;
    end else if (busy) begin
      quo   <= {quo[DivNumW-2:0], ge};
      rem_r <= ge ? 24'(trial - {1'b0, dsr}) : trial[23:0];
    end
  end

  assign quot = quo;
  assign rem  = rem_r;

endmodule

@@ rtl/ktsd_datapath.sv @@
// Datapath: tuning state, divider operands, results and the output register.
`timescale 1ns / 1ps
module ktsd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  ktsd_pkg::in_t     in_data,
  input  logic              cfg_we,
  input  logic [29:0]       cfg_data,
  input  ktsd_pkg::cmd_t    cmd,
  output ktsd_pkg::status_t st,
  output ktsd_pkg::out_t    out_data
);
  import ktsd_pkg::*;

  logic [VcoWidth-1:0] vco;
  logic [3:0]  digits [6];
  logic [3:0]  digits_next [6];
  logic [2:0]  cursor, cursor_next;
  logic        scroll, scroll_next;
  logic        handled, handled_next;
  logic        updated, updated_next;
  logic [23:0] rgb;
  logic [23:0] f, f_next;
  logic [29:0] q;
  logic [23:0] rem0, num, den, x, y;
  logic [6:0]  dint, phase;
  logic [19:0] dnum, dden;
  logic [2:0]  op;
  logic [43:0] div_a;
  logic [23:0] div_b;
  logic        div_busy, div_done;
  logic [43:0] quot;
  logic [23:0] rem;
  logic [30:0] ph;

  ktsd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // event decode
  always_comb begin
    logic [3:0] d;
    logic [7:0] m;
    logic [3:0] rot;
    for (int i = 0; i < 6; i++) digits_next[i] = digits[i];
    cursor_next  = cursor;
    scroll_next  = scroll;
    handled_next = 1'b0;
    updated_next = 1'b0;
    d   = digits[cursor];
    m   = 8'(digits[5]) * 8'd10 + 8'(digits[4]);
    m   = m + (in_data.turn_left ? 8'd7 : 8'd1);
    rot = {1'b1, m[2:0]};
    if (in_data.encoder_present) begin
      if (in_data.button_pressed) begin
        scroll_next = ~scroll;
      end else if (in_data.knob_moved) begin
        handled_next = 1'b1;
        if (scroll) begin
          cursor_next = (cursor == 3'd4) ? 3'd0 : cursor + 3'd1;
        end else begin
          updated_next = 1'b1;
          if (cursor < 3'd4) begin
            if (in_data.turn_left) d = (d == 4'd0) ? 4'd9 : d - 4'd1;
            else                   d = (d >= 4'd9) ? 4'd0 : d + 4'd1;
            digits_next[cursor] = d;
          end else begin
            digits_next[5] = (rot >= 4'd10) ? 4'd1 : 4'd0;
            digits_next[4] = (rot >= 4'd10) ? rot - 4'd10 : rot;
          end
        end
      end
    end
  end

  assign f_next = 24'(digits[0]) * 24'd100 + 24'(digits[1]) * 24'd1000
                + 24'(digits[2]) * 24'd10000 + 24'(digits[3]) * 24'd100000
                + 24'(digits[4]) * 24'd1000000 + 24'(digits[5]) * 24'd10000000;

  always_comb begin
    div_a = {20'd0, y};
    div_b = x;
    unique case (cmd.div_op)
      OP_VCO: begin div_a = {14'd0, vco}; div_b = f; end
      OP_EUC: begin div_a = {20'd0, y};   div_b = x; end
      OP_NUM: begin div_a = {20'd0, num}; div_b = y; end
      OP_DEN: begin div_a = {20'd0, den}; div_b = y; end
      OP_SCL: begin div_a = {num, 20'd0} - {20'd0, num}; div_b = den; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vco    <= VcoReset;
      digits <= '{4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd1};
      cursor <= 3'd2;
      scroll <= 1'b0;
    end else begin
      if (cfg_we) vco <= cfg_data;
      if (cmd.capture) begin
        digits <= digits_next;
        cursor <= cursor_next;
        scroll <= scroll_next;
      end
    end
  end

  assign ph = 31'(q) + 31'({rem0, 1'b0} >= {1'b0, f});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      handled <= handled_next;
      updated <= updated_next;
      rgb     <= in_data.encoder_present ? colour(mod7(in_data.rotation_count)) : 24'd0;
      dint    <= '0;
      dnum    <= '0;
      dden    <= '0;
      phase   <= '0;
    end
    if (cmd.f_load) f <= f_next;
    if (cmd.div_start) op <= cmd.div_op;
    if (div_done) begin
      unique case (op)
        OP_VCO: begin
          q    <= quot[29:0];
          rem0 <= rem;
          num  <= rem;
          den  <= f;
          x    <= rem;
          y    <= f;
        end
        OP_EUC: begin y <= x; x <= rem; end
        OP_NUM: num <= quot[23:0];
        OP_DEN: den <= quot[23:0];
        OP_SCL: begin num <= quot[23:0]; den <= FracLimit; end
        default: ;
      endcase
    end
    if (cmd.res_load) begin
      dint  <= (q > 30'd127) ? 7'd127 : q[6:0];
      phase <= (ph > 31'd127) ? 7'd127 : ph[6:0];
      dnum  <= num[19:0];
      dden  <= den[19:0];
    end
    if (cmd.out_load) begin
      out_data.event_handled       <= handled;
      out_data.pll_updated         <= updated;
      out_data.frequency_hz        <= f;
      out_data.cursor_position     <= cursor;
      out_data.divider_integer     <= dint;
      out_data.divider_numerator   <= dnum;
      out_data.divider_denominator <= dden;
      out_data.quadrature_phase    <= phase;
      out_data.led_red             <= rgb[23:16];
      out_data.led_green           <= rgb[15:8];
      out_data.led_blue            <= rgb[7:0];
      out_data.scroll_active       <= scroll;
    end
  end

  assign st.div_busy = div_busy;
  assign st.div_done = div_done;
  assign st.x_zero   = (x == 24'd0);
  assign st.den_big  = (den > FracLimit);
  assign st.calc_ok  = updated && (f != 24'd0);

endmodule

@@ rtl/ktsd_ctrl.sv @@
// Controller: sequences capture, divider passes, Euclid loop and output beat.
`timescale 1ns / 1ps
module ktsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ktsd_pkg::status_t st,
  output ktsd_pkg::cmd_t    cmd
);
  import ktsd_pkg::*;
  `include "knob_tuned_synth_divider_macros.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FCAL = 4'd1;
  localparam logic [3:0] S_CHKF = 4'd2;
  localparam logic [3:0] S_WVCO = 4'd3;
  localparam logic [3:0] S_EUCL = 4'd4;
  localparam logic [3:0] S_WEUC = 4'd5;
  localparam logic [3:0] S_WNUM = 4'd6;
  localparam logic [3:0] S_WDEN = 4'd7;
  localparam logic [3:0] S_SCHK = 4'd8;
  localparam logic [3:0] S_WSCL = 4'd9;
  localparam logic [3:0] S_RES  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state, state_next;
  logic       in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_op = OP_VCO;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.capture = 1'b1;
        state_next  = S_FCAL;
      end
      S_FCAL: begin
        cmd.f_load = 1'b1;
        state_next = S_CHKF;
      end
      S_CHKF: begin
        if (st.calc_ok) begin
          cmd.div_start = 1'b1;
          state_next    = S_WVCO;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WVCO: if (st.div_done) state_next = S_EUCL;
      S_EUCL: begin
        cmd.div_start = 1'b1;
        if (st.x_zero) begin
          cmd.div_op = OP_NUM;
          state_next = S_WNUM;
        end else begin
          cmd.div_op = OP_EUC;
          state_next = S_WEUC;
        end
      end
      S_WEUC: if (st.div_done) state_next = S_EUCL;
      S_WNUM: if (st.div_done) begin
        cmd.div_start = 1'b1;
        cmd.div_op    = OP_DEN;
        state_next    = S_WDEN;
      end
      S_WDEN: if (st.div_done) state_next = S_SCHK;
      S_SCHK: begin
        if (st.den_big) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_SCL;
          state_next    = S_WSCL;
        end else begin
          state_next = S_RES;
        end
      end
      S_WSCL: if (st.div_done) state_next = S_RES;
      S_RES: begin
        cmd.res_load = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: if (!out_valid || out_ready) begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `KTSD_ASSERT_IMP(a_start_idle_div, clk, rst, cmd.div_start, !st.div_busy)
  `KTSD_ASSERT_IMP(a_idle_no_div, clk, rst, state == S_IDLE, !st.div_busy)
  `KTSD_ASSERT_NXT(a_capture_then_f, clk, rst, in_fire, state == S_FCAL)
  `KTSD_ASSERT_NXT(a_load_sets_valid, clk, rst, cmd.out_load, out_valid)

endmodule

@@ tb/sv/knob_tuned_synth_divider_checker.sv @@
// Checker for the knob-tuned synthesizer divider: predicts each event and compares results.
`timescale 1ns / 1ps
module knob_tuned_synth_divider_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  ktsd_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  ktsd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [29:0]    cfg_data,
  output int             fail_count,
  output int             pending
);
  import ktsd_pkg::*;

  logic [3:0]  digits [6];
  logic [2:0]  cur;
  logic        scroll;
  logic [29:0] vco_hz;
  out_t        tuned_q[$];

  assign pending = tuned_q.size();

  function automatic logic [23:0] freq_of();
    logic [31:0] f;
    f = 32'(digits[0]) * 100 + 32'(digits[1]) * 1000 + 32'(digits[2]) * 10000
      + 32'(digits[3]) * 100000 + 32'(digits[4]) * 1000000
      + 32'(digits[5]) * 10000000;
    return f[23:0];
  endfunction

  function automatic out_t tune_event(in_t ev);
    out_t o;
    logic [31:0] f, q, num, den, a, b, t, m, rot;
    logic [63:0] ph;
    logic [23:0] rgb;
    o = '0;
    if (ev.encoder_present) begin
      case (ev.rotation_count % 7)
        0: rgb = {8'd255, 8'd0, 8'd0};
        1: rgb = {8'd255, 8'd165, 8'd0};
        2: rgb = {8'd255, 8'd255, 8'd0};
        3: rgb = {8'd0, 8'd128, 8'd0};
        4: rgb = {8'd0, 8'd0, 8'd255};
        5: rgb = {8'd75, 8'd0, 8'd130};
        default: rgb = {8'd238, 8'd130, 8'd238};
      endcase
      {o.led_red, o.led_green, o.led_blue} = rgb;
      if (ev.button_pressed) begin
        scroll = ~scroll;
      end else if (ev.knob_moved) begin
        if (scroll) begin
          cur = (cur == 3'd4) ? 3'd0 : cur + 3'd1;
        end else begin
          if (cur < 3'd4) begin
            digits[cur] = ev.turn_left ? (digits[cur] == 0 ? 4'd9 : digits[cur] - 4'd1)
                                       : (digits[cur] == 9 ? 4'd0 : digits[cur] + 4'd1);
          end else begin
            m = 32'(digits[5]) * 10 + 32'(digits[4]) + (ev.turn_left ? 7 : 1);
            rot = 8 + m % 8;
            digits[4] = 4'(rot % 10);
            digits[5] = 4'(rot / 10);
          end
          o.pll_updated = 1'b1;
        end
        o.event_handled = 1'b1;
      end
    end
    if (o.pll_updated) begin
      f = 32'(freq_of());
      if (f != 0) begin
        q = 32'(vco_hz) / f;
        num = 32'(vco_hz) % f;
        den = f;
        a = num;
        b = den;
        while (a != 0) begin
          t = b % a;
          b = a;
          a = t;
        end
        num = num / b;
        den = den / b;
        if (den > 32'hFFFFF) begin
          num = 32'((64'(num) * 64'hFFFFF) / 64'(den));
          den = 32'hFFFFF;
        end
        ph = (64'(vco_hz) * 2 + 64'(f)) / (64'(f) * 2);
        o.divider_integer = (q > 127) ? 7'd127 : q[6:0];
        o.quadrature_phase = (ph > 127) ? 7'd127 : ph[6:0];
        o.divider_numerator = num[19:0];
        o.divider_denominator = den[19:0];
      end
    end
    o.frequency_hz = freq_of();
    o.cursor_position = cur;
    o.scroll_active = scroll;
    return o;
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (rst) begin
      digits = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd1};
      cur = 3'd2;
      scroll = 1'b0;
      vco_hz = VcoReset;
      fail_count = 0;
      tuned_q.delete();
    end else begin
      if (cfg_we) vco_hz = cfg_data;
      if (out_valid && out_ready) begin
        if (tuned_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          exp_r = tuned_q.pop_front();
          if (out_data !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p got %p", exp_r, out_data);
          end
        end
      end
      if (in_valid && in_ready) tuned_q.push_back(tune_event(in_data));
    end
  end
endmodule

@@ tb/sv/knob_tuned_synth_divider_test.sv @@
// Testbench top for the knob-tuned synthesizer divider: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module knob_tuned_synth_divider_test;
  import ktsd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [29:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycle = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  knob_tuned_synth_divider dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  knob_tuned_synth_divider_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 2000000) begin
      $display("FAIL knob_tuned_synth_divider");
      $finish;
    end
  end

  // the block never takes two beats in a row, so the extra falling edge costs nothing
  task automatic send_beat(input in_t ev);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic turn(input logic left, input logic [15:0] count);
    send_beat('{1'b1, 1'b0, 1'b1, left, count});
  endtask

  task automatic press();
    send_beat('{1'b1, 1'b1, 1'b0, 1'b0, 16'($urandom)});
  endtask

  // drain, let the divider settle, then retune the VCO
  task automatic set_vco(input logic [29:0] hz);
    while (pending != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= hz;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_beat();
    in_t ev;
    int  kind;
    kind = $urandom_range(99);
    ev = in_t'($urandom);
    ev.encoder_present = (kind >= 8);
    if (kind >= 8) begin
      ev.button_pressed = (kind < 25);
      ev.knob_moved = (kind >= 25) ? 1'b1 : ev.knob_moved;
    end
    send_beat(ev);
  endtask

  initial begin
    int ph;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    // directed: absent encoder, extremes of count, digit wrap downward, cursor wrap
    send_beat('{1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF});
    send_beat('{1'b1, 1'b0, 1'b0, 1'b0, 16'h0000});
    turn(1'b0, 16'hFFFF);
    turn(1'b1, 16'd6);
    turn(1'b1, 16'd5);
    press();
    repeat (3) turn(1'b0, 16'd3);
    press();
    repeat (9) turn(1'b1, 16'd1);
    turn(1'b0, 16'd2);
    press();
    repeat (3) turn(1'b0, 16'd4);
    press();
    turn(1'b0, 16'd0);
    set_vco(30'd600000000);
    turn(1'b1, 16'd7);
    set_vco(30'h3FFFFFFF);
    turn(1'b0, 16'd8);
    set_vco(30'd0);
    turn(1'b1, 16'd9);
    set_vco(30'd900000000);
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 59) : 0;
      stall_pct = (ph == 2) ? 59 : ((ph == 3) ? 24 : 0);
      repeat (28) random_beat();
      // sender holds off until everything is back
      while (pending != 0) @(negedge clk);
      set_vco(30'($urandom_range(900000000, 600000000)));
    end
    while (pending != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS knob_tuned_synth_divider");
    end else begin
      $display("FAIL knob_tuned_synth_divider");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/ktsd_pkg.sv
rtl/ktsd_divider.sv
rtl/ktsd_datapath.sv
rtl/ktsd_ctrl.sv
rtl/knob_tuned_synth_divider.sv
tb/sv/knob_tuned_synth_divider_checker.sv
tb/sv/knob_tuned_synth_divider_test.sv
